/* hw/rtl/configurable_crc_stream_engine_macros.svh */
// Assertion macros shared by the CRC stream engine RTL.
// Depends on nothing; users must have aclk and aresetn in scope.
`ifndef CONFIGURABLE_CRC_STREAM_ENGINE_MACROS_SVH
`define CONFIGURABLE_CRC_STREAM_ENGINE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CCSE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define CCSE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* hw/rtl/ccse_pkg.sv */
// Package for the CRC stream engine: widths, register indexes, reset values.
// Holds the 64-bit reversal function. Depends on nothing.
package ccse_pkg;

    localparam int CRC_W         = 64;
    localparam int MAX_CRC_WIDTH = 64;
    localparam int CW_W          = 7;
    localparam int SH_W          = 6;
    localparam int LEN_W         = 4;
    localparam int BYTE_W        = 8;
    localparam int CFG_IDX_W     = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CRC_WIDTH      = 3'd0,
        CFG_POLYNOMIAL     = 3'd1,
        CFG_INITIAL_VALUE  = 3'd2,
        CFG_REFLECT_INPUT  = 3'd3,
        CFG_REFLECT_OUTPUT = 3'd4,
        CFG_FINAL_XOR      = 3'd5
    } cfg_index_t;

    localparam logic [CW_W-1:0]   RST_CRC_WIDTH  = 7'd32;
    localparam logic [CRC_W-1:0]  RST_POLYNOMIAL = 64'h0000_0000_04C1_1DB7;
    localparam logic [CRC_W-1:0]  RST_INIT       = 64'h0000_0000_FFFF_FFFF;
    localparam logic [CRC_W-1:0]  RST_FINAL_XOR  = 64'h0000_0000_FFFF_FFFF;
    localparam logic [LEN_W-1:0]  MAX_BITS       = 4'd8;

    function automatic logic [CRC_W-1:0] rev64(input logic [CRC_W-1:0] x);
        logic [CRC_W-1:0] r;
        for (int i = 0; i < CRC_W; i++) begin
            r[i] = x[CRC_W-1-i];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/configurable_crc_stream_engine.sv */
// Top level of the programmable CRC stream engine (width 1 to 64).
// Depends on ccse_pkg and configurable_crc_stream_engine_macros.svh.
// Usage:
//   s_* channel: one message byte per request with 1 to 8 valid bits
//   (low bits when input is reflected, high bits otherwise), plus first,
//   resume/start_value and last flags. first restarts the running CRC from
//   initial_value, or with resume from a finished CRC given in start_value.
//   m_* channel: one request carrying the finished CRC for every byte that
//   has last set; bytes without last produce nothing.
//   cfg_* channel: register writes, index per the register list; write only
//   while no request is in flight.
// Datapath: input register, logic (load, eight unrolled XOR-shift steps,
//   finish), result register; a last byte's CRC enters it once the slot is free.
//   One byte per cycle unless s_ready drops; the eight steps set the clock.
// Configuration: derived values (aligned polynomial, shift, mask) are
//   registered, so s_ready drops in the write cycle and the cycle after it,
//   and in the first cycle after reset.
// Reset: registers return to CRC-32 defaults, the working CRC clears to zero,
//   both valids drop. While m_* stalls, bytes without last keep flowing; a
//   last byte holds in the input register and blocks s_ready until the result is taken.
`include "configurable_crc_stream_engine_macros.svh"

module configurable_crc_stream_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ccse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ccse_pkg::CRC_W-1:0]    cfg_data,
    // input byte channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ccse_pkg::BYTE_W-1:0]   s_data_byte,
    input  logic [ccse_pkg::LEN_W-1:0]    s_bit_count,
    input  logic                          s_first,
    input  logic                          s_resume,
    input  logic [ccse_pkg::CRC_W-1:0]    s_start_value,
    input  logic                          s_last,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ccse_pkg::CRC_W-1:0]    m_crc_value
);
    import ccse_pkg::*;

    // Programmer-visible registers.
    logic [CW_W-1:0]  crc_width_reg;
    logic [CRC_W-1:0] polynomial_reg;
    logic [CRC_W-1:0] initial_value_reg;
    logic             reflect_input_reg;
    logic             reflect_output_reg;
    logic [CRC_W-1:0] final_xor_reg;

    // Derived configuration, registered from the programmer-visible registers.
    logic [SH_W-1:0]  shift_reg;
    logic [CRC_W-1:0] mask_reg;
    logic [CRC_W-1:0] poly_al_reg;
    logic [CRC_W-1:0] fresh_al_reg;
    logic [CRC_W-1:0] fxor_reg;
    logic             refl_reg;
    logic             diff_reg;
    logic             cfg_pend_reg;

    logic [CW_W-1:0]  width_eff;
    logic [SH_W-1:0]  shift_next;
    logic [CRC_W-1:0] mask_next;
    logic [CRC_W-1:0] poly_al_next;
    logic [CRC_W-1:0] fresh_al_next;

    // Input register.
    logic             in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic [LEN_W-1:0] in_len_reg;
    logic             in_first_reg;
    logic             in_last_reg;
    logic [CRC_W-1:0] in_load_reg;

    logic [LEN_W-1:0] len_sat;
    logic [BYTE_W-1:0] byte_masked;
    logic [CRC_W-1:0] resume_masked;
    logic [CRC_W-1:0] resume_al;
    logic [CRC_W-1:0] load_next;

    // Working CRC and result register.
    logic [CRC_W-1:0] crc_reg;
    logic [CRC_W-1:0] crc_next;
    logic [CRC_W-1:0] crc_fin;
    logic             m_valid_reg;
    logic [CRC_W-1:0] m_crc_value_reg;

    logic out_free;
    logic advance;
    logic s_take;

    // ------------------------------------------------------------------
    // Configuration write port: always ready, indexes past the list drop.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_width_reg      <= RST_CRC_WIDTH;
            polynomial_reg     <= RST_POLYNOMIAL;
            initial_value_reg  <= RST_INIT;
            reflect_input_reg  <= 1'b1;
            reflect_output_reg <= 1'b1;
            final_xor_reg      <= RST_FINAL_XOR;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_CRC_WIDTH:      crc_width_reg      <= cfg_data[CW_W-1:0];
                CFG_POLYNOMIAL:     polynomial_reg     <= cfg_data;
                CFG_INITIAL_VALUE:  initial_value_reg  <= cfg_data;
                CFG_REFLECT_INPUT:  reflect_input_reg  <= cfg_data[0];
                CFG_REFLECT_OUTPUT: reflect_output_reg <= cfg_data[0];
                CFG_FINAL_XOR:      final_xor_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Derived configuration. Clamp the width to 1..MAX_CRC_WIDTH, then
    // align polynomial and init to the low bits (reflected) or the top bits.
    // ------------------------------------------------------------------
    always_comb begin
        if (crc_width_reg == '0) begin
            width_eff = CW_W'(1);
        end else if (crc_width_reg > CW_W'(MAX_CRC_WIDTH)) begin
            width_eff = CW_W'(MAX_CRC_WIDTH);
        end else begin
            width_eff = crc_width_reg;
        end
        shift_next = SH_W'(CW_W'(CRC_W) - width_eff);
        mask_next  = {CRC_W{1'b1}} >> shift_next;
        if (reflect_input_reg) begin
            poly_al_next  = rev64(polynomial_reg) >> shift_next;
            fresh_al_next = rev64(initial_value_reg) >> shift_next;
        end else begin
            poly_al_next  = (polynomial_reg & mask_next) << shift_next;
            fresh_al_next = (initial_value_reg & mask_next) << shift_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg    <= shift_next;
        mask_reg     <= mask_next;
        poly_al_reg  <= poly_al_next;
        fresh_al_reg <= fresh_al_next;
        fxor_reg     <= final_xor_reg & mask_next;
        refl_reg     <= reflect_input_reg;
        diff_reg     <= reflect_input_reg ^ reflect_output_reg;
    end

    // Hold off input while derived values catch up with a write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_pend_reg <= 1'b1;
        end else begin
            cfg_pend_reg <= cfg_valid && cfg_ready;
        end
    end

    // ------------------------------------------------------------------
    // Handshake. A last byte advances only when the result slot is free.
    // ------------------------------------------------------------------
    assign out_free = !m_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready  = !cfg_pend_reg && !cfg_valid && (!in_valid_reg || advance);
    assign s_take   = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Input side: saturate bit count, trim the byte, prepare the load value.
    // ------------------------------------------------------------------
    always_comb begin
        len_sat = (s_bit_count > MAX_BITS) ? MAX_BITS : s_bit_count;
        if (refl_reg) begin
            byte_masked = s_data_byte & (8'hff >> (MAX_BITS - len_sat));
        end else begin
            byte_masked = s_data_byte & (8'hff << (MAX_BITS - len_sat));
        end
        // Undo the final XOR and output reflection of a resumed CRC.
        resume_masked = (s_start_value & mask_reg) ^ fxor_reg;
        if (refl_reg) begin
            resume_al = diff_reg ? (rev64(resume_masked) >> shift_reg) : resume_masked;
        end else begin
            resume_al = diff_reg ? rev64(resume_masked) : (resume_masked << shift_reg);
        end
        load_next = s_resume ? resume_al : fresh_al_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_byte_reg  <= byte_masked;
            in_len_reg   <= len_sat;
            in_first_reg <= s_first;
            in_last_reg  <= s_last;
            in_load_reg  <= load_next;
        end
    end

    // ------------------------------------------------------------------
    // Absorb up to eight bits, then finish for the result.
    // ------------------------------------------------------------------
    always_comb begin
        crc_next = in_first_reg ? in_load_reg : crc_reg;
        if (refl_reg) begin
            crc_next = crc_next ^ {{(CRC_W-BYTE_W){1'b0}}, in_byte_reg};
            for (int i = 0; i < BYTE_W; i++) begin
                if (LEN_W'(i) < in_len_reg) begin
                    crc_next = (crc_next >> 1) ^ (crc_next[0] ? poly_al_reg : '0);
                end
            end
        end else begin
            crc_next = crc_next ^ {in_byte_reg, {(CRC_W-BYTE_W){1'b0}}};
            for (int i = 0; i < BYTE_W; i++) begin
                if (LEN_W'(i) < in_len_reg) begin
                    crc_next = (crc_next << 1) ^ (crc_next[CRC_W-1] ? poly_al_reg : '0);
                end
            end
        end
        if (refl_reg) begin
            crc_fin = diff_reg ? (rev64(crc_next) >> shift_reg) : crc_next;
        end else begin
            crc_fin = diff_reg ? rev64(crc_next) : (crc_next >> shift_reg);
        end
        crc_fin = (crc_fin ^ fxor_reg) & mask_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= '0;
        end else if (advance) begin
            crc_reg <= crc_next;
        end
    end

    // Result register: load on a last byte, drop once taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            m_crc_value_reg <= crc_fin;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_crc_value = m_crc_value_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `CCSE_ASSERT(a_rise_from_last, $rose(m_valid_reg) |-> $past(advance && in_last_reg),
        "result appeared without a last byte")
    `CCSE_ASSERT(a_result_value,
        advance && in_last_reg |=> m_valid_reg && m_crc_value_reg == $past(crc_fin),
        "result register did not capture the finished CRC")
    `CCSE_ASSERT(a_no_take_on_cfg, cfg_pend_reg |-> !s_take,
        "byte taken while derived configuration was stale")
    `CCSE_ASSERT_ALWAYS(a_reset_clears,
        !aresetn |=> !m_valid_reg && !in_valid_reg && crc_reg == '0,
        "reset did not clear valids and working CRC")

endmodule

/* dv/configurable_crc_stream_engine_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for configurable_crc_stream_engine.
// Uses ccse_pkg for widths, register indexes and reset values; nothing else.

module configurable_crc_stream_engine_tb;

    import ccse_pkg::*;

    // Cycles without any handshake on any channel before the run is declared hung.
    localparam int STALL_LIMIT = 2000;
    // Cycles to let the pipeline settle after the last expected CRC has come.
    localparam int SETTLE_CYCLES = 6;
    localparam int NUM_SETTINGS = 10;
    localparam int REQS_PER_SETTING = 38;

    // One request on the byte channel, held in the pending queue until driven.
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  bit_count;
        logic              first;
        logic              resume;
        logic [CRC_W-1:0]  start_value;
        logic              last;
    } byte_req_t;

    logic                 aclk;
    logic                 aresetn       = 1'b0;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    cfg_index_t           cfg_index     = CFG_CRC_WIDTH;
    logic [CRC_W-1:0]     cfg_data      = '0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_data_byte   = '0;
    logic [LEN_W-1:0]     s_bit_count   = '0;
    logic                 s_first       = 1'b0;
    logic                 s_resume      = 1'b0;
    logic [CRC_W-1:0]     s_start_value = '0;
    logic                 s_last        = 1'b0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [CRC_W-1:0]     m_crc_value;

    configurable_crc_stream_engine u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_bit_count   (s_bit_count),
        .s_first       (s_first),
        .s_resume      (s_resume),
        .s_start_value (s_start_value),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_crc_value   (m_crc_value)
    );

    // ------------------------------------------------------------------
    // Scoreboard state: shadow copy of the registers, the running CRC,
    // requests waiting to be driven and CRCs waiting to come out.
    // ------------------------------------------------------------------
    logic [CW_W-1:0]  shadow_width  = RST_CRC_WIDTH;
    logic [CRC_W-1:0] shadow_poly   = RST_POLYNOMIAL;
    logic [CRC_W-1:0] shadow_init   = RST_INIT;
    logic             shadow_rin    = 1'b1;
    logic             shadow_rout   = 1'b1;
    logic [CRC_W-1:0] shadow_fxor   = RST_FINAL_XOR;
    logic [CRC_W-1:0] running_crc   = '0;
    logic [CRC_W-1:0] recent_crc    = '0;

    byte_req_t        pending_bytes[$];
    logic [CRC_W-1:0] expected_crcs[$];

    int send_idle_pct = 33;
    int recv_idle_pct = 85;
    int error_count = 0;
    int reqs_queued = 0;
    int reqs_taken = 0;
    int crcs_checked = 0;
    int stall_cycles = 0;
    logic req_taken = 1'b0;

    // ------------------------------------------------------------------
    // CRC predictor
    // ------------------------------------------------------------------
    function automatic logic [CRC_W-1:0] low_mask(input int w);
        return (w >= CRC_W) ? '1 : ((64'd1 << w) - 64'd1);
    endfunction

    // Mirror the low w bits; everything above comes back zero.
    function automatic logic [CRC_W-1:0] mirror_low(input logic [CRC_W-1:0] x, input int w);
        logic [CRC_W-1:0] r;
        r = '0;
        for (int i = 0; i < w; i++) begin
            r[w-1-i] = x[i];
        end
        return r;
    endfunction

    // Width 0 acts as 1, anything past the maximum clamps to it.
    function automatic int active_width();
        int w;
        w = shadow_width;
        if (w < 1) w = 1;
        if (w > MAX_CRC_WIDTH) w = MAX_CRC_WIDTH;
        return w;
    endfunction

    // Place a normal-form value into the working register's alignment.
    function automatic logic [CRC_W-1:0] align_in(input logic [CRC_W-1:0] x, input int w);
        if (shadow_rin) return mirror_low(x, w);
        return (x & low_mask(w)) << (CRC_W - w);
    endfunction

    // Advance the running CRC by one byte request; queue the finished CRC on last.
    function automatic void advance_crc(input byte_req_t r);
        int w;
        int nbits;
        logic [CRC_W-1:0] poly_al;
        logic [CRC_W-1:0] c;
        logic [7:0] keep;
        w = active_width();
        nbits = (r.bit_count > 8) ? 8 : int'(r.bit_count);
        if (r.first) begin
            if (r.resume) begin
                // undo the final XOR and output reflection of the earlier CRC
                c = (r.start_value ^ shadow_fxor) & low_mask(w);
                if (shadow_rin ^ shadow_rout) c = mirror_low(c, w);
                if (!shadow_rin) c = c << (CRC_W - w);
                running_crc = c;
            end else begin
                running_crc = align_in(shadow_init, w);
            end
        end
        poly_al = align_in(shadow_poly, w);
        if (shadow_rin) begin
            keep = 8'hff >> (8 - nbits);
            running_crc = running_crc ^ {56'd0, r.data_byte & keep};
            for (int i = 0; i < nbits; i++) begin
                running_crc = (running_crc >> 1) ^ (running_crc[0] ? poly_al : '0);
            end
        end else begin
            keep = 8'hff << (8 - nbits);
            running_crc = running_crc ^ {r.data_byte & keep, 56'd0};
            for (int i = 0; i < nbits; i++) begin
                running_crc = (running_crc << 1) ^ (running_crc[CRC_W-1] ? poly_al : '0);
            end
        end
        if (r.last) begin
            c = running_crc;
            if (!shadow_rin) c = c >> (CRC_W - w);
            if (shadow_rin ^ shadow_rout) c = mirror_low(c, w);
            c = (c ^ shadow_fxor) & low_mask(w);
            expected_crcs.push_back(c);
            recent_crc = c;
        end
    endfunction

    function automatic logic [CRC_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Byte driver: present a new request at the falling edge once the
    // previous one has been taken; idle at random per send_idle_pct.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : byte_driver
        byte_req_t next_req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_taken) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_req = pending_bytes.pop_front();
                s_valid       <= 1'b1;
                s_data_byte   <= next_req.data_byte;
                s_bit_count   <= next_req.bit_count;
                s_first       <= next_req.first;
                s_resume      <= next_req.resume;
                s_start_value <= next_req.start_value;
                s_last        <= next_req.last;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Record each accepted request and run it through the predictor.
    always @(posedge aclk) begin : byte_accept
        req_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            advance_crc('{s_data_byte, s_bit_count, s_first, s_resume,
                          s_start_value, s_last});
            reqs_taken++;
        end
    end

    // Receiver back-pressure: stall at random per recv_idle_pct.
    always @(negedge aclk) begin : result_ready
        m_ready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each accepted CRC with the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_monitor
        logic [CRC_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_crcs.size() == 0) begin
                $error("crc_value: no result expected, actual %h", m_crc_value);
                error_count++;
            end else begin
                want = expected_crcs.pop_front();
                if (m_crc_value !== want) begin
                    $error("crc_value: expected %h, actual %h", want, m_crc_value);
                    error_count++;
                end
                crcs_checked++;
            end
        end
    end

    // Watchdog: end the run with a failure once stall_cycles reaches STALL_LIMIT.
    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_req(input logic [7:0] data_byte, input logic [3:0] bit_count,
                            input logic first, input logic resume,
                            input logic [CRC_W-1:0] start_value, input logic last);
        pending_bytes.push_back('{data_byte, bit_count, first, resume, start_value, last});
        reqs_queued++;
    endtask

    // Hold the sender until every queued request is taken and every CRC is out.
    // Look just after the falling edge so the driver's update has landed.
    task automatic wait_for_results();
        do begin
            @(negedge aclk);
            #1;
        end while (pending_bytes.size() != 0 || s_valid || expected_crcs.size() != 0);
    endtask

    // Write one register; leave cfg_valid high so back-to-back writes do not toggle it.
    task automatic write_reg(input cfg_index_t idx, input logic [CRC_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk);
        while (!cfg_ready);
        case (idx)
            CFG_CRC_WIDTH:      shadow_width = value[CW_W-1:0];
            CFG_POLYNOMIAL:     shadow_poly  = value;
            CFG_INITIAL_VALUE:  shadow_init  = value;
            CFG_REFLECT_INPUT:  shadow_rin   = value[0];
            CFG_REFLECT_OUTPUT: shadow_rout  = value[0];
            CFG_FINAL_XOR:      shadow_fxor  = value;
            default: ;
        endcase
    endtask

    // Program a full CRC setting. Upper bits of the width and reflect registers carry junk
    // that the block must ignore.
    task automatic program_setting(input int width, input logic [CRC_W-1:0] poly,
                                   input logic [CRC_W-1:0] init, input logic rin,
                                   input logic rout, input logic [CRC_W-1:0] fxor);
        write_reg(CFG_CRC_WIDTH, {57'(rand64()), CW_W'(width)});
        write_reg(CFG_POLYNOMIAL, poly);
        write_reg(CFG_INITIAL_VALUE, init);
        write_reg(CFG_REFLECT_INPUT, {63'(rand64()), rin});
        write_reg(CFG_REFLECT_OUTPUT, {63'(rand64()), rout});
        write_reg(CFG_FINAL_XOR, fxor);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Queue one well-formed message: first on the opening byte, last on the
    // closing one; the opening byte may resume from an earlier CRC or a random value.
    task automatic queue_message(input int n_bytes);
        logic resume_it;
        logic [CRC_W-1:0] seed;
        logic [3:0] bc;
        resume_it = ($urandom_range(99) < 30);
        seed = ($urandom_range(1) != 0) ? recent_crc : rand64();
        for (int i = 0; i < n_bytes; i++) begin
            bc = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'd8;
            push_req(8'($urandom), bc, i == 0, (i == 0) ? resume_it : 1'($urandom),
                     (i == 0) ? seed : rand64(), i == n_bytes - 1);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        string check_str;
        int phase_reqs;
        bit paused;
        int width;
        logic rin;
        logic rout;
        logic [CRC_W-1:0] poly;
        logic [CRC_W-1:0] init;
        logic [CRC_W-1:0] fxor;

        check_str = "123456789";
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed requests under the reset setting (CRC-32).
        // A message with no first since reset runs on from the cleared register.
        push_req(8'hff, 4'd8, 1'b0, 1'b0, '0, 1'b1);
        // Standard check string.
        for (int i = 0; i < 9; i++) begin
            push_req(8'(check_str[i]), 4'd8, i == 0, 1'b0, '0, i == 8);
        end
        // No bits absorbed, but still a fresh start and an emitted CRC.
        push_req(8'hab, 4'd0, 1'b1, 1'b0, '0, 1'b1);
        // Oversized bit count clamps to eight; resume from an all-ones CRC.
        push_req(8'h00, 4'd15, 1'b1, 1'b1, '1, 1'b1);
        // Carry on after last with resume set but no first: both are ignored.
        push_req(8'hff, 4'd9, 1'b0, 1'b1, rand64(), 1'b0);
        push_req(8'h01, 4'd1, 1'b0, 1'b0, '0, 1'b1);
        // Resume from zero with a partial byte.
        push_req(8'h80, 4'd7, 1'b1, 1'b1, '0, 1'b0);
        push_req(8'h00, 4'd8, 1'b0, 1'b0, '1, 1'b1);
        push_req(8'h5a, 4'd4, 1'b1, 1'b0, 64'h0123_4567_89ab_cdef, 1'b1);

        for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
            wait_for_results();
            repeat (SETTLE_CYCLES) @(negedge aclk);

            // sender light / receiver heavy, then swapped, then free running
            if (ph < 3) begin
                send_idle_pct = 33;
                recv_idle_pct = 85;
            end else if (ph < 6) begin
                send_idle_pct = 85;
                recv_idle_pct = 33;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            width = $urandom_range(64, 1);
            poly = rand64() | 64'd1;
            init = rand64();
            fxor = rand64();
            rin = 1'($urandom);
            rout = 1'($urandom);
            case (ph)
                0: begin width = 64;  rin = 1'b0; rout = 1'b0; end
                1: begin width = 1;   rin = 1'b1; rout = 1'b0; end
                // width zero behaves as width one
                2: begin width = 0;   rin = 1'b0; rout = 1'b1; end
                // beyond the maximum: clamps to 64
                3: begin width = 127; rin = 1'b1; rout = 1'b1; end
                4: begin
                    width = 8;
                    rin = 1'b0;
                    rout = 1'b0;
                    poly = {56'(rand64()), 8'h07};
                    init = {56'(rand64()), 8'h00};
                    fxor = {56'(rand64()), 8'h00};
                end
                // even polynomial goes in unchecked
                5: begin width = 16;  poly = poly & ~64'd1; end
                default: ;
            endcase
            program_setting(width, poly, init, rin, rout, fxor);

            phase_reqs = reqs_queued;
            paused = 1'b0;
            while (reqs_queued - phase_reqs < REQS_PER_SETTING) begin
                if ($urandom_range(99) < 12) begin
                    // noise: flags and fields fully random
                    push_req(8'($urandom), 4'($urandom_range(15)), 1'($urandom),
                             1'($urandom), rand64(), 1'($urandom));
                end else begin
                    queue_message($urandom_range(6, 1));
                end
                // hold the sender once per setting until the block has drained
                if (!paused && reqs_queued - phase_reqs >= REQS_PER_SETTING / 2) begin
                    wait_for_results();
                    paused = 1'b1;
                end
            end
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("summary: %0d byte requests taken over %0d register settings",
                 reqs_taken, NUM_SETTINGS + 1);
        $display("summary: %0d CRC results checked, %0d mismatches",
                 crcs_checked, error_count);
        if (error_count == 0 && expected_crcs.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
